[rtl/core/gmlm_pkg.sv]
// Package for the grid minimum-of-local-maxima block: sizes, register map, config limits.
// Used by gmlm_top-level grid_min_of_local_maxima; depends on nothing.
`timescale 1ns / 1ps

package gmlm_pkg;

  localparam int MAX_COLS      = 1024;
  localparam int PIXEL_BITS    = 32;
  localparam int COL_BITS      = $clog2(MAX_COLS);
  localparam int COL_CNT_BITS  = $clog2(MAX_COLS + 1);
  localparam int ROW_CFG_BITS  = 16;
  localparam int COL_CFG_BITS  = 11;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam int MIN_COUNT     = 2;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_e;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

endpackage

[rtl/core/gmlm_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// No package dependency; sized by WIDTH and DEPTH.
`timescale 1ns / 1ps

module gmlm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/grid_min_of_local_maxima.sv]
// Top level: four-neighbor local maximum detection over a raster frame, minimum of maxima.
// Depends on gmlm_pkg and gmlm_ram (line RAM holding the two latest rows per column).
// Throughput: one pixel beat per cycle; input stalls only while a frame end waits behind
//   an unaccepted result. The frame's last beat passes stages 1 to 4, then loads the result register.
// Reset: asynchronous; clears positions, running minimum, pipeline valids, output valid and found;
//   both counts return to 2. Line RAM contents are not cleared.
`timescale 1ns / 1ps

module grid_min_of_local_maxima (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gmlm_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [gmlm_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [gmlm_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [gmlm_pkg::PIXEL_BITS-1:0] pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [gmlm_pkg::PIXEL_BITS-1:0] min_local_max_o,
  output logic                                found_o
);

  typedef struct packed {
    logic en0;
    logic en1;
    logic en2;
    logic en3;
    logic has_up;
    logic has_left;
    logic last;
  } flags_t;

  // configuration
  logic [gmlm_pkg::ROW_CFG_BITS-1:0] row_cfg_q;
  logic [gmlm_pkg::COL_CFG_BITS-1:0] col_cfg_q;
  logic                              cfg_wr;
  gmlm_pkg::reg_idx_e                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = gmlm_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      gmlm_pkg::REG_ROW_COUNT: prdata = gmlm_pkg::APB_DATA_BITS'(row_cfg_q);
      gmlm_pkg::REG_COL_COUNT: prdata = gmlm_pkg::APB_DATA_BITS'(col_cfg_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q <= gmlm_pkg::ROW_CFG_BITS'(gmlm_pkg::MIN_COUNT);
      col_cfg_q <= gmlm_pkg::COL_CFG_BITS'(gmlm_pkg::MIN_COUNT);
    end else if (cfg_wr) begin
      case (cfg_idx)
        gmlm_pkg::REG_ROW_COUNT: row_cfg_q <= pwdata[gmlm_pkg::ROW_CFG_BITS-1:0];
        gmlm_pkg::REG_COL_COUNT: col_cfg_q <= pwdata[gmlm_pkg::COL_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [gmlm_pkg::COL_CNT_BITS-1:0] cols_eff;
  logic [gmlm_pkg::COL_BITS-1:0]     last_col;
  logic [gmlm_pkg::ROW_CFG_BITS-1:0] rows_eff;
  logic [gmlm_pkg::ROW_CFG_BITS-1:0] last_row;

  always_comb begin
    if (col_cfg_q > gmlm_pkg::MAX_COLS) begin
      cols_eff = gmlm_pkg::COL_CNT_BITS'(gmlm_pkg::MAX_COLS);
    end else if (col_cfg_q < gmlm_pkg::MIN_COUNT) begin
      cols_eff = gmlm_pkg::COL_CNT_BITS'(gmlm_pkg::MIN_COUNT);
    end else begin
      cols_eff = gmlm_pkg::COL_CNT_BITS'(col_cfg_q);
    end
    if (row_cfg_q < gmlm_pkg::MIN_COUNT) begin
      rows_eff = gmlm_pkg::ROW_CFG_BITS'(gmlm_pkg::MIN_COUNT);
    end else begin
      rows_eff = row_cfg_q;
    end
  end

  assign last_col = gmlm_pkg::COL_BITS'(cols_eff - gmlm_pkg::COL_CNT_BITS'(1));
  assign last_row = rows_eff - gmlm_pkg::ROW_CFG_BITS'(1);

  // handshake and stall
  logic   stall;
  logic   accept;
  logic   s4_valid_q;
  logic   s4_last_q;

  assign stall      = s4_valid_q & s4_last_q & out_valid_o & ~out_ready_i;
  assign in_ready_o = ~stall;
  assign accept     = in_valid_i & in_ready_o;

  // frame position
  logic [gmlm_pkg::COL_BITS-1:0]     col_pos_q, col_pos_d;
  logic [gmlm_pkg::ROW_CFG_BITS-1:0] row_pos_q, row_pos_d;
  logic                              col_wrap;
  logic                              row_wrap;

  assign col_wrap = (col_pos_q == last_col);
  assign row_wrap = (row_pos_q == last_row);

  always_comb begin
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    if (cfg_wr) begin
      col_pos_d = '0;
      row_pos_d = '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_pos_d = '0;
        row_pos_d = row_wrap ? '0 : row_pos_q + gmlm_pkg::ROW_CFG_BITS'(1);
      end else begin
        col_pos_d = col_pos_q + gmlm_pkg::COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else begin
      col_pos_q <= col_pos_d;
      row_pos_q <= row_pos_d;
    end
  end

  // line RAM: each column holds {row r-1, row r-2}
  logic [2*gmlm_pkg::PIXEL_BITS-1:0] ram_rdata;
  gmlm_pkg::pixel_t                  rd_hi;
  gmlm_pkg::pixel_t                  rd_lo;

  assign rd_hi = gmlm_pkg::pixel_t'(ram_rdata[2*gmlm_pkg::PIXEL_BITS-1:gmlm_pkg::PIXEL_BITS]);
  assign rd_lo = gmlm_pkg::pixel_t'(ram_rdata[gmlm_pkg::PIXEL_BITS-1:0]);

  gmlm_ram #(
    .WIDTH (2 * gmlm_pkg::PIXEL_BITS),
    .DEPTH (gmlm_pkg::MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_pos_q),
    .wdata_i ({pixel_i, rd_hi}),
    .raddr_i (col_pos_d),
    .rdata_o (ram_rdata)
  );

  // stage 1: pixel window
  gmlm_pkg::pixel_t w_cur_q, w_p1_q, w_p2_q;
  gmlm_pkg::pixel_t w_hi_q, w_hi1_q, w_hi2_q;
  gmlm_pkg::pixel_t w_lo_q, w_lo1_q;
  logic             s1_valid_q;
  flags_t           s1_flags_q;
  flags_t           s1_flags_d;
  logic             row_ge1;

  assign row_ge1 = (row_pos_q != '0);

  always_comb begin
    s1_flags_d.en0      = row_ge1 & (col_pos_q != '0);
    s1_flags_d.en1      = row_ge1 & col_wrap;
    s1_flags_d.en2      = row_wrap & (col_pos_q != '0);
    s1_flags_d.en3      = row_wrap & col_wrap;
    s1_flags_d.has_up   = (row_pos_q > gmlm_pkg::ROW_CFG_BITS'(1));
    s1_flags_d.has_left = (col_pos_q > gmlm_pkg::COL_BITS'(1));
    s1_flags_d.last     = row_wrap & col_wrap;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_cur_q    <= pixel_i;
      w_p1_q     <= w_cur_q;
      w_p2_q     <= w_p1_q;
      w_hi_q     <= rd_hi;
      w_hi1_q    <= w_hi_q;
      w_hi2_q    <= w_hi1_q;
      w_lo_q     <= rd_lo;
      w_lo1_q    <= w_lo_q;
      s1_flags_q <= s1_flags_d;
    end
  end

  // stage 2: neighbor compares
  logic             s2_valid_q;
  logic             s2_last_q;
  gmlm_pkg::pixel_t s2_val_q [4];
  logic [3:0]       s2_ok_q;
  logic [3:0]       ok_d;
  flags_t           f1;

  assign f1 = s1_flags_q;

  always_comb begin
    ok_d[0] = f1.en0 & (~f1.has_up | (w_hi1_q > w_lo1_q)) & (w_hi1_q > w_p1_q)
            & (~f1.has_left | (w_hi1_q > w_hi2_q)) & (w_hi1_q > w_hi_q);
    ok_d[1] = f1.en1 & (~f1.has_up | (w_hi_q > w_lo_q)) & (w_hi_q > w_cur_q)
            & (w_hi_q > w_hi1_q);
    ok_d[2] = f1.en2 & (w_p1_q > w_hi1_q) & (~f1.has_left | (w_p1_q > w_p2_q))
            & (w_p1_q > w_cur_q);
    ok_d[3] = f1.en3 & (w_cur_q > w_hi_q) & (w_cur_q > w_p1_q);
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s2_val_q[0] <= w_hi1_q;
      s2_val_q[1] <= w_hi_q;
      s2_val_q[2] <= w_p1_q;
      s2_val_q[3] <= w_cur_q;
      s2_ok_q     <= ok_d;
      s2_last_q   <= f1.last;
    end
  end

  // stage 3: pair minimum
  logic             s3_valid_q;
  logic             s3_last_q;
  gmlm_pkg::pixel_t s3_val_q [2];
  logic [1:0]       s3_ok_q;

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int i = 0; i < 2; i++) begin
        s3_ok_q[i] <= s2_ok_q[2*i] | s2_ok_q[2*i+1];
        if (s2_ok_q[2*i] && (!s2_ok_q[2*i+1] || (s2_val_q[2*i] < s2_val_q[2*i+1]))) begin
          s3_val_q[i] <= s2_val_q[2*i];
        end else begin
          s3_val_q[i] <= s2_val_q[2*i+1];
        end
      end
      s3_last_q <= s2_last_q;
    end
  end

  // stage 4: beat minimum
  gmlm_pkg::pixel_t s4_val_q;
  logic             s4_ok_q;

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s4_ok_q <= s3_ok_q[0] | s3_ok_q[1];
      if (s3_ok_q[0] && (!s3_ok_q[1] || (s3_val_q[0] < s3_val_q[1]))) begin
        s4_val_q <= s3_val_q[0];
      end else begin
        s4_val_q <= s3_val_q[1];
      end
      s4_last_q <= s3_last_q;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // running minimum and result register
  gmlm_pkg::pixel_t run_min_q;
  logic             run_found_q;
  gmlm_pkg::pixel_t merged_min;
  logic             merged_found;
  gmlm_pkg::pixel_t out_min_q;
  logic             out_found_q;
  logic             out_valid_q;
  logic             s4_fire;

  assign s4_fire      = s4_valid_q & ~stall;
  assign merged_found = run_found_q | s4_ok_q;
  assign merged_min   = (s4_ok_q && (!run_found_q || (s4_val_q < run_min_q))) ?
                        s4_val_q : run_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q   <= '0;
      run_found_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        run_min_q   <= '0;
        run_found_q <= 1'b0;
      end else if (s4_fire) begin
        if (s4_last_q) begin
          run_min_q   <= '0;
          run_found_q <= 1'b0;
        end else begin
          run_min_q   <= merged_min;
          run_found_q <= merged_found;
        end
      end
      if (s4_fire && s4_last_q) begin
        out_valid_q <= 1'b1;
        out_found_q <= merged_found;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_fire && s4_last_q) begin
      out_min_q <= merged_min;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign min_local_max_o = out_min_q;
  assign found_o         = out_found_q;

  // checks
  a_nofound_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> min_local_max_o == '0)
    else $error("result without a local maximum carries a nonzero minimum");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && s4_valid_q && s4_last_q)
    else $error("input held off without a pending frame result");

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_pos_q <= last_col)
    else $error("column position beyond the row length");

  a_last_beat_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_fire && s4_last_q |=> out_valid_o)
    else $error("frame end did not load the result register");

endmodule
